// ===== hdl/kwm_pkg.sv =====
package kwm_pkg;

    localparam int MAX_LISTS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int LISTS_RESET     = 16;

endpackage

// ===== hdl/kwm_if.sv =====
interface kwm_in_if #(
    parameter int IDX_W = $clog2(kwm_pkg::MAX_LISTS_DEF),
    parameter int VAL_W = kwm_pkg::VALUE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        list_index;
    logic signed [VAL_W-1:0] value;
    logic                    end_of_list;

    modport source (output valid, list_index, value, end_of_list, input ready);
    modport sink   (input valid, list_index, value, end_of_list, output ready);
endinterface

interface kwm_out_if #(
    parameter int IDX_W = $clog2(kwm_pkg::MAX_LISTS_DEF),
    parameter int VAL_W = kwm_pkg::VALUE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] merged_value;
    logic [IDX_W-1:0]        source_list;
    logic                    all_done;

    modport source (output valid, merged_value, source_list, all_done, input ready);
    modport sink   (input valid, merged_value, source_list, all_done, output ready);
endinterface

interface kwm_cfg_if #(
    parameter int CNT_W = $clog2(kwm_pkg::MAX_LISTS_DEF + 1)
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/k_way_sorted_stream_merge.sv =====
// Merges up to MAX_LISTS ascending signed streams into one ascending stream.
// Lists 0 .. lists_in_use-1 take part (zero counts as one, values above
// MAX_LISTS saturate). Heads live in a small RAM; per-list present/ended
// flags live in flops. A request is taken in S_IDLE and checked in S_DECIDE;
// when every live list holds a head, the head RAM is swept once over the
// lists in use in S_SCAN and the smallest head (lowest index on ties) is
// registered for output in S_EMIT, which waits while the output is stalled.
// No new request is taken until the block is back in S_IDLE. When all lists
// in use have ended, an all_done result with zero fields is emitted and the
// flags clear; lists_in_use is kept.
module k_way_sorted_stream_merge #(
    parameter int MAX_LISTS   = kwm_pkg::MAX_LISTS_DEF,
    parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kwm_cfg_if.sink   i_cfg,
    kwm_in_if.sink    i_in_item,
    kwm_out_if.source o_result
);

    localparam int IDX_W = $clog2(MAX_LISTS);
    localparam int CNT_W = $clog2(MAX_LISTS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]                    r_state;
    logic [CNT_W-1:0]              r_cfg;
    logic [MAX_LISTS-1:0]          r_present;
    logic [MAX_LISTS-1:0]          r_ended;
    logic [IDX_W-1:0]              r_ptr;
    logic [IDX_W-1:0]              r_best_idx;
    logic signed [VALUE_WIDTH-1:0] r_best_val;
    logic                          r_found;
    logic                          r_ov;
    logic signed [VALUE_WIDTH-1:0] r_oval;
    logic [IDX_W-1:0]              r_osrc;
    logic                          r_odone;

    logic [CNT_W-1:0]       used_cnt;
    logic [MAX_LISTS-1:0]   used;
    logic                   all_ended;
    logic                   all_ready;
    logic                   out_free;
    logic                   set_ov;
    logic                   in_acc;
    logic                   idx_ok;
    logic                   take;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   cand;
    logic                   less;
    logic                   last;

    always_comb begin
        priority if (r_cfg == '0) begin
            used_cnt = CNT_W'(1);
        end else if (int'(r_cfg) > MAX_LISTS) begin
            used_cnt = CNT_W'(MAX_LISTS);
        end else begin
            used_cnt = r_cfg;
        end
        for (int i = 0; i < MAX_LISTS; i++) begin
            used[i] = i < int'(used_cnt);
        end
    end

    assign all_ended = &(~used | r_ended);
    assign all_ready = &(~used | r_ended | r_present);
    assign out_free  = !r_ov || o_result.ready;
    assign set_ov    = out_free && (((r_state == S_DECIDE) && all_ended)
                                    || (r_state == S_EMIT));

    assign i_cfg.ready     = 1'b1;
    assign i_in_item.ready = (r_state == S_IDLE);
    assign in_acc          = i_in_item.valid && i_in_item.ready;
    assign idx_ok          = used[i_in_item.list_index]
                             && !r_ended[i_in_item.list_index]
                             && !r_present[i_in_item.list_index];
    assign take            = in_acc && idx_ok;
    assign ram_we          = take && !i_in_item.end_of_list;
    assign ram_raddr       = (r_state == S_SCAN) ? r_ptr + IDX_W'(1) : '0;

    // entry r_ptr arrives from the RAM while in S_SCAN
    assign cand = used[r_ptr] && r_present[r_ptr];
    assign less = !r_found || ($signed(ram_rdata) < r_best_val);
    assign last = (CNT_W'(r_ptr) == used_cnt - CNT_W'(1));

    kwm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_LISTS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_item.list_index),
        .i_wdata (i_in_item.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CNT_W'(MAX_LISTS < kwm_pkg::LISTS_RESET ?
                                MAX_LISTS : kwm_pkg::LISTS_RESET);
            r_present <= '0;
            r_ended   <= '0;
            r_found   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cfg <= i_cfg.data;
            end
            if (set_ov) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (take) begin
                            if (i_in_item.end_of_list) begin
                                r_ended[i_in_item.list_index] <= 1'b1;
                            end else begin
                                r_present[i_in_item.list_index] <= 1'b1;
                            end
                        end
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    priority if (all_ended) begin
                        if (out_free) begin
                            r_oval    <= '0;
                            r_osrc    <= '0;
                            r_odone   <= 1'b1;
                            r_present <= '0;
                            r_ended   <= '0;
                            r_state   <= S_IDLE;
                        end
                    end else if (all_ready) begin
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (cand && less) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_ptr;
                        r_best_val <= $signed(ram_rdata);
                    end
                    if (last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_ptr <= r_ptr + IDX_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_oval                <= r_best_val;
                        r_osrc                <= r_best_idx;
                        r_odone               <= 1'b0;
                        r_present[r_best_idx] <= 1'b0;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.merged_value = r_oval;
    assign o_result.source_list  = r_osrc;
    assign o_result.all_done     = r_odone;

endmodule

// ===== hdl/kwm_ram.sv =====
module kwm_ram #(
    parameter int WIDTH = kwm_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = kwm_pkg::MAX_LISTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/kwm_chk.sv =====
module kwm_chk #(
    parameter int IDX_W = $clog2(kwm_pkg::MAX_LISTS_DEF),
    parameter int VAL_W = kwm_pkg::VALUE_WIDTH_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VAL_W-1:0] i_out_value,
    input logic [IDX_W-1:0] i_out_src,
    input logic             i_out_done
);

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_value == '0 && i_out_src == '0)
        else $error("all_done result with nonzero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
        && $stable(i_out_src) && $stable(i_out_done))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one still in work");

    a_no_result_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared one cycle after request");

endmodule

bind k_way_sorted_stream_merge kwm_chk #(
    .IDX_W ($clog2(MAX_LISTS)),
    .VAL_W (VALUE_WIDTH)
) u_kwm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_item.valid),
    .i_in_ready  (i_in_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.merged_value),
    .i_out_src   (o_result.source_list),
    .i_out_done  (o_result.all_done)
);
